@@ hw/rtl/nmtk_pkg.sv @@
// shared types, constants and codes of the nearest match top-k list
`default_nettype none

package nmtk_pkg;

  // sizes
  localparam int DefListDepth = 16;
  localparam int MaxReadout   = 16;
  localparam int TAG_W        = 32;
  localparam int DELTA_W      = 33;
  localparam int RANK_W       = 4;
  localparam int TIME_W       = 32;
  localparam int RANGE_W      = 24;
  localparam int RMARGIN_W    = 25;
  localparam int VAL_W        = 32;
  localparam int CFG_AW       = 3;
  localparam int CFG_DW       = 32;
  localparam int IN_DW        = 344;
  localparam int OUT_DW       = 72;
  localparam int OUT_UW       = 2;

  localparam logic [DELTA_W-1:0] DeltaEmpty = '1;

  // configuration register indexes
  typedef enum logic [CFG_AW-1:0] {
    CFG_TIME_MARGIN  = 3'd0,
    CFG_RANGE_MARGIN = 3'd1,
    CFG_PROP_SEL     = 3'd2,
    CFG_USE_RATE     = 3'd3,
    CFG_CASE_TIME    = 3'd4,
    CFG_CASE_RANGE   = 3'd5,
    CFG_CASE_VALUE   = 3'd6
  } cfg_idx_e;

  // compared property
  typedef enum logic [1:0] {
    PROP_VOLUME = 2'd0,
    PROP_AREA   = 2'd1,
    PROP_MASS   = 2'd2,
    PROP_FLUX   = 2'd3
  } prop_e;

  // result kind
  typedef enum logic [OUT_UW-1:0] {
    STAT_INSERT    = 2'd0,
    STAT_REJ_TIME  = 2'd1,
    STAT_REJ_RANGE = 2'd2,
    STAT_READOUT   = 2'd3
  } status_e;

  // per-cell operation
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_LOAD   = 2'd1,
    CELL_SHIFT  = 2'd2,
    CELL_ROTATE = 2'd3
  } cell_op_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } state_e;

  // one list slot
  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [DELTA_W-1:0] delta;
    logic               valid;
  } entry_t;

  // configuration as seen by the evaluator
  typedef struct packed {
    logic [TIME_W-1:0]    time_limit;
    logic [RMARGIN_W-1:0] range_limit;
    prop_e                prop_sel;
    logic                 use_rate;
    logic [TIME_W-1:0]    case_time;
    logic [RANGE_W-1:0]   case_range;
    logic [VAL_W-1:0]     case_value;
  } cfg_t;

  // one offered candidate
  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [TIME_W-1:0]  sample_time;
    logic [RANGE_W-1:0] sample_range;
    logic [VAL_W-1:0]   area_value;
    logic [VAL_W-1:0]   volume_value;
    logic [VAL_W-1:0]   mass_value;
    logic [VAL_W-1:0]   flux_value;
    logic [VAL_W-1:0]   area_rate;
    logic [VAL_W-1:0]   volume_rate;
    logic [VAL_W-1:0]   mass_rate;
    logic [VAL_W-1:0]   flux_rate;
  } item_t;

  // outcome of the checks and the distance of a candidate
  typedef struct packed {
    status_e            status;
    logic [DELTA_W-1:0] delta;
  } verdict_t;

endpackage

`default_nettype wire

@@ hw/rtl/nmtk_cell.sv @@
// one slot of the sorted list: compares against the offered delta and moves data
`default_nettype none

module nmtk_cell (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire nmtk_pkg::cell_op_e            op_i,
  input  wire nmtk_pkg::entry_t              new_i,
  input  wire nmtk_pkg::entry_t              prev_i,
  input  wire nmtk_pkg::entry_t              next_i,
  input  wire logic [nmtk_pkg::DELTA_W-1:0]  probe_delta_i,
  output nmtk_pkg::entry_t                   ent_o,
  output logic                               le_o
);
  import nmtk_pkg::*;

  entry_t ent_q, ent_d;

  // slot ranks ahead of the candidate when its delta is not larger
  assign le_o = (ent_q.delta <= probe_delta_i);

  // next slot contents
  always_comb begin
    case (op_i)
      CELL_LOAD:   ent_d = new_i;
      CELL_SHIFT:  ent_d = prev_i;
      CELL_ROTATE: ent_d = next_i;
      default:     ent_d = ent_q;
    endcase
  end

  // slot register, empty after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q.tag   <= '0;
      ent_q.delta <= DeltaEmpty;
      ent_q.valid <= 1'b0;
    end else begin
      ent_q <= ent_d;
    end
  end

  assign ent_o = ent_q;

endmodule

`default_nettype wire

@@ hw/rtl/nmtk_eval.sv @@
// time and range window checks and distance of a candidate from the case
`default_nettype none

module nmtk_eval (
  input  wire nmtk_pkg::cfg_t  cfg_i,
  input  wire nmtk_pkg::item_t item_i,
  output nmtk_pkg::verdict_t   verdict_o
);
  import nmtk_pkg::*;

  logic [TIME_W-1:0]  time_diff;
  logic [RANGE_W-1:0] range_diff;
  logic               time_bad;
  logic               range_bad;
  logic [VAL_W-1:0]   sel_value;
  logic [DELTA_W-1:0] val_a;
  logic [DELTA_W-1:0] val_b;
  logic [DELTA_W-1:0] fwd;
  logic [DELTA_W-1:0] bwd;
  logic [DELTA_W-1:0] delta;

  // time window, disabled by a negative margin
  assign time_diff = (item_i.sample_time >= cfg_i.case_time) ?
                     item_i.sample_time - cfg_i.case_time :
                     cfg_i.case_time - item_i.sample_time;
  assign time_bad  = !cfg_i.time_limit[TIME_W-1] &&
                     (time_diff > {1'b0, cfg_i.time_limit[TIME_W-2:0]});

  // range window, disabled by a negative margin
  assign range_diff = (item_i.sample_range >= cfg_i.case_range) ?
                      item_i.sample_range - cfg_i.case_range :
                      cfg_i.case_range - item_i.sample_range;
  assign range_bad  = !cfg_i.range_limit[RMARGIN_W-1] &&
                      (range_diff > cfg_i.range_limit[RANGE_W-1:0]);

  // pick the compared quantity
  always_comb begin
    case (cfg_i.prop_sel)
      PROP_VOLUME: sel_value = cfg_i.use_rate ? item_i.volume_rate : item_i.volume_value;
      PROP_AREA:   sel_value = cfg_i.use_rate ? item_i.area_rate   : item_i.area_value;
      PROP_MASS:   sel_value = cfg_i.use_rate ? item_i.mass_rate   : item_i.mass_value;
      default:     sel_value = cfg_i.use_rate ? item_i.flux_rate   : item_i.flux_value;
    endcase
  end

  // absolute difference in one bit more than the operands
  assign val_a = {sel_value[VAL_W-1], sel_value};
  assign val_b = {cfg_i.case_value[VAL_W-1], cfg_i.case_value};
  assign fwd   = val_a - val_b;
  assign bwd   = val_b - val_a;
  assign delta = ($signed(val_a) >= $signed(val_b)) ? fwd : bwd;

  // time check wins over range check
  always_comb begin
    verdict_o.delta = delta;
    if (time_bad) begin
      verdict_o.status = STAT_REJ_TIME;
    end else if (range_bad) begin
      verdict_o.status = STAT_REJ_RANGE;
    end else begin
      verdict_o.status = STAT_INSERT;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/nearest_match_top_k_list.sv @@
// nearest match top-k list: a chain of sorted slots fed by offers and read out on request
//
// Input beats carry either an offer (tuser 0) or a readout request (tuser 1).
// An offer is checked against the time and range windows; if it passes, its
// distance from the case value is compared in every slot at once and the
// chain shifts to open its sorted place, dropping the last slot. One result
// beat follows each offer in the cycle after acceptance, and a new offer is
// taken every cycle while the output is drained.
// A readout request rotates the chain through slot 0 by LIST_DEPTH positions:
// the first min(LIST_DEPTH, 16) positions go out as beats with tlast on the
// final one, the rest rotate silently so the list ends where it began. No
// input is taken until the rotation, with any output stalls, is complete.
// Reset empties every slot (tag 0, delta all ones, not valid) and loads the
// register defaults. When the receiver stalls, the held result waits in the
// output register and input is taken only once that register can be freed.
// Configuration writes take effect at the next edge and belong in idle time.
`default_nettype none

module nearest_match_top_k_list #(
  parameter int LIST_DEPTH = nmtk_pkg::DefListDepth
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // configuration write port
  input  wire logic                         cfg_we_i,
  input  wire logic [nmtk_pkg::CFG_AW-1:0]  cfg_addr_i,
  input  wire logic [nmtk_pkg::CFG_DW-1:0]  cfg_wdata_i,
  // input stream
  input  wire logic                         s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // track_tag, sample_time, sample_range, area_value, volume_value, mass_value,
  // flux_value, area_rate, volume_rate, mass_rate, flux_rate
  input  wire logic [nmtk_pkg::IN_DW-1:0]   s_axis_tdata_i,
  // req_type
  input  wire logic                         s_axis_tuser_i,
  // result stream
  output logic                              m_axis_tvalid_o,
  input  wire logic                         m_axis_tready_i,
  // rank, entry_tag, entry_delta, entry_valid, zero fill
  output logic [nmtk_pkg::OUT_DW-1:0]       m_axis_tdata_o,
  // status
  output logic [nmtk_pkg::OUT_UW-1:0]       m_axis_tuser_o,
  output logic                              m_axis_tlast_o
);
  import nmtk_pkg::*;

  localparam int NumOut = (LIST_DEPTH < MaxReadout) ? LIST_DEPTH : MaxReadout;
  localparam int CW     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam logic [CW-1:0] LastRot  = CW'(LIST_DEPTH - 1);
  localparam logic [CW-1:0] LastRead = CW'(NumOut - 1);
  localparam logic [CW:0]   NumOutC  = (CW + 1)'(NumOut);

  // configuration registers
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.time_limit   <= '1;
      cfg_q.range_limit  <= '1;
      cfg_q.prop_sel     <= PROP_VOLUME;
      cfg_q.use_rate     <= 1'b0;
      cfg_q.case_time    <= '0;
      cfg_q.case_range   <= '0;
      cfg_q.case_value   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        CFG_TIME_MARGIN:  cfg_q.time_limit   <= cfg_wdata_i[TIME_W-1:0];
        CFG_RANGE_MARGIN: cfg_q.range_limit  <= cfg_wdata_i[RMARGIN_W-1:0];
        CFG_PROP_SEL:     cfg_q.prop_sel     <= prop_e'(cfg_wdata_i[1:0]);
        CFG_USE_RATE:     cfg_q.use_rate     <= cfg_wdata_i[0];
        CFG_CASE_TIME:    cfg_q.case_time    <= cfg_wdata_i[TIME_W-1:0];
        CFG_CASE_RANGE:   cfg_q.case_range   <= cfg_wdata_i[RANGE_W-1:0];
        CFG_CASE_VALUE:   cfg_q.case_value   <= cfg_wdata_i[VAL_W-1:0];
        default:          ;
      endcase
    end
  end

  // unpack the input beat
  item_t item;

  assign item.tag          = s_axis_tdata_i[31:0];
  assign item.sample_time  = s_axis_tdata_i[63:32];
  assign item.sample_range = s_axis_tdata_i[87:64];
  assign item.area_value   = s_axis_tdata_i[119:88];
  assign item.volume_value = s_axis_tdata_i[151:120];
  assign item.mass_value   = s_axis_tdata_i[183:152];
  assign item.flux_value   = s_axis_tdata_i[215:184];
  assign item.area_rate    = s_axis_tdata_i[247:216];
  assign item.volume_rate  = s_axis_tdata_i[279:248];
  assign item.mass_rate    = s_axis_tdata_i[311:280];
  assign item.flux_rate    = s_axis_tdata_i[343:312];

  // window checks and distance
  verdict_t verdict;

  nmtk_eval u_eval (
    .cfg_i     (cfg_q),
    .item_i    (item),
    .verdict_o (verdict)
  );

  // control
  state_e          state_q, state_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            out_vld_q, out_vld_d;
  logic            out_free;
  logic            in_acc;
  logic            offer_acc;
  logic            offer_ins;
  logic            read_acc;
  logic            emit_phase;
  logic            rotate;
  logic            read_emit;

  assign out_free   = !out_vld_q || m_axis_tready_i;
  assign in_acc     = s_axis_tvalid_i && s_axis_tready_o;
  assign offer_acc  = in_acc && !s_axis_tuser_i;
  assign read_acc   = in_acc && s_axis_tuser_i;
  assign offer_ins  = offer_acc && (verdict.status == STAT_INSERT);
  assign emit_phase = ({1'b0, cnt_q} < NumOutC);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (read_acc) state_d = ST_READ;
      ST_READ: if (rotate && (cnt_q == LastRot)) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    s_axis_tready_o = 1'b0;
    rotate          = 1'b0;
    read_emit       = 1'b0;
    unique case (state_q)
      ST_IDLE: s_axis_tready_o = out_free;
      ST_READ: begin
        rotate    = emit_phase ? out_free : 1'b1;
        read_emit = emit_phase && out_free;
      end
      default: ;
    endcase
  end

  // rotation counter
  always_comb begin
    cnt_d = cnt_q;
    if (rotate) begin
      cnt_d = (cnt_q == LastRot) ? '0 : cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // slot chain
  entry_t                 cell_ent [LIST_DEPTH];
  cell_op_e               cell_op  [LIST_DEPTH];
  logic [LIST_DEPTH-1:0]  le;
  logic [LIST_DEPTH-1:0]  le_eff;
  logic [LIST_DEPTH-1:0]  le_prev;
  logic [LIST_DEPTH-1:0]  ins;
  logic [LIST_DEPTH-1:0]  shift;
  logic [RANK_W-1:0]      rank_enc;
  entry_t                 new_ent;

  assign new_ent.tag   = item.tag;
  assign new_ent.delta = verdict.delta;
  assign new_ent.valid = 1'b1;

  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    nmtk_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .op_i          (cell_op[i]),
      .new_i         (new_ent),
      .prev_i        (cell_ent[(i == 0) ? 0 : i - 1]),
      .next_i        (cell_ent[(i + 1) % LIST_DEPTH]),
      .probe_delta_i (verdict.delta),
      .ent_o         (cell_ent[i]),
      .le_o          (le[i])
    );
  end

  // the last slot is always taken when nothing earlier fits
  always_comb begin
    le_eff = le;
    le_eff[LIST_DEPTH-1] = 1'b0;
  end

  // insertion point is the first slot past the run of smaller-or-equal deltas
  assign le_prev = LIST_DEPTH'({le_eff, 1'b1});
  assign ins     = ~le_eff & le_prev;
  assign shift   = ~le_prev;

  // per-cell operations and rank of the insertion slot
  always_comb begin
    rank_enc = '0;
    for (int i = 0; i < LIST_DEPTH; i++) begin
      if (rotate) begin
        cell_op[i] = CELL_ROTATE;
      end else if (!offer_ins) begin
        cell_op[i] = CELL_HOLD;
      end else if (ins[i]) begin
        cell_op[i] = CELL_LOAD;
      end else if (shift[i]) begin
        cell_op[i] = CELL_SHIFT;
      end else begin
        cell_op[i] = CELL_HOLD;
      end
      if (ins[i]) begin
        rank_enc = rank_enc | RANK_W'(i);
      end
    end
  end

  // output register
  status_e            out_status_q, out_status_d;
  logic [RANK_W-1:0]  out_rank_q, out_rank_d;
  entry_t             out_ent_q, out_ent_d;
  logic               out_last_q, out_last_d;

  always_comb begin
    out_status_d = out_status_q;
    out_rank_d   = out_rank_q;
    out_ent_d    = out_ent_q;
    out_last_d   = out_last_q;
    out_vld_d    = m_axis_tready_i ? 1'b0 : out_vld_q;
    if (offer_acc) begin
      out_vld_d     = 1'b1;
      out_status_d  = verdict.status;
      out_last_d    = 1'b1;
      out_ent_d.tag = item.tag;
      if (verdict.status == STAT_INSERT) begin
        out_rank_d      = rank_enc;
        out_ent_d.delta = verdict.delta;
        out_ent_d.valid = 1'b1;
      end else begin
        out_rank_d      = '0;
        out_ent_d.delta = '0;
        out_ent_d.valid = 1'b0;
      end
    end else if (read_emit) begin
      out_vld_d    = 1'b1;
      out_status_d = STAT_READOUT;
      out_rank_d   = RANK_W'(cnt_q);
      out_ent_d    = cell_ent[0];
      out_last_d   = (cnt_q == LastRead);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_status_q <= out_status_d;
    out_rank_q   <= out_rank_d;
    out_ent_q    <= out_ent_d;
    out_last_q   <= out_last_d;
  end

  // pack the result beat
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = {2'b00, out_ent_q.valid, out_ent_q.delta, out_ent_q.tag, out_rank_q};

  // checks
  a_ins_onehot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> $onehot(ins))
    else $error("insertion point is not unique");

  a_sorted_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |->
      (cell_ent[0].delta <= cell_ent[(LIST_DEPTH > 1) ? 1 : 0].delta))
    else $error("list head out of order while idle");

  a_offer_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    offer_acc |=> (out_vld_q && out_last_q && (state_q == ST_IDLE)))
    else $error("offer did not produce a single result beat");

  a_read_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    read_acc |=> ((state_q == ST_READ) && (cnt_q == '0)))
    else $error("readout request did not start the rotation");

endmodule

`default_nettype wire
